// File: src/assert_macros.svh
// Assertion macros shared by the frame buffer pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds on a rising edge of i_clk outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: src/fbpm_pkg.sv
// Types and codes of the frame buffer pool manager.
package fbpm_pkg;

    localparam logic       ACT_REQUEST  = 1'b0;
    localparam logic       ACT_RELEASE  = 1'b1;

    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_MOTION  = 2'd1;
    localparam logic [1:0] KIND_EXTRA   = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_NO_FREE   = 3'd1;
    localparam logic [2:0] ST_NO_REF    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_RELEASED  = 3'd4;
    localparam logic [2:0] ST_REL_ERROR = 3'd5;

    localparam logic [2:0] REF_NONE     = 3'd6;

    localparam int         CNT_W        = 2;
    localparam logic [1:0] CNT_PAIR     = 2'd2;
    localparam logic [1:0] CNT_SINGLE   = 2'd1;

    localparam logic       SCAN_GRAB    = 1'b0;
    localparam logic       SCAN_DROP    = 1'b1;

    typedef struct packed {
        logic       action;
        logic [1:0] frame_kind;
        logic [2:0] release_id;
    } t_fbpm_in;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] granted_id;
        logic       freed;
        logic [2:0] reference_id;
    } t_fbpm_out;

    typedef struct packed {
        logic start;
        logic mode;
    } t_scan_cmd;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_sts;

endpackage

// File: src/fbpm_slot_scan.sv
// Free and used slot lists with a one-slot-per-cycle scanner.
`include "assert_macros.svh"

module fbpm_slot_scan #(
    parameter int FRAME_COUNT = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fbpm_pkg::t_scan_cmd               i_cmd,
    input  logic [$clog2(FRAME_COUNT)-1:0]    i_frame,
    output fbpm_pkg::t_scan_sts               o_sts,
    output logic [$clog2(FRAME_COUNT)-1:0]    o_frame
);
    import fbpm_pkg::*;

    localparam int IW = $clog2(FRAME_COUNT);
    localparam logic [IW-1:0] LAST = IW'(FRAME_COUNT - 1);

    logic [FRAME_COUNT-1:0] r_free_vld;
    logic [IW-1:0]          r_free_id [FRAME_COUNT];
    logic [FRAME_COUNT-1:0] r_used_vld;
    logic [IW-1:0]          r_used_id [FRAME_COUNT];

    logic          r_run;
    logic          r_fin;
    logic          r_mode;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_frame;
    logic          r_hit;
    logic [IW-1:0] r_take;
    logic          r_pos_ok;
    logic [IW-1:0] r_pos;

    logic          free_v;
    logic [IW-1:0] free_i;
    logic          used_v;
    logic [IW-1:0] used_i;
    logic          free_match;

    assign free_v     = r_free_vld[r_idx];
    assign free_i     = r_free_id[r_idx];
    assign used_v     = r_used_vld[r_idx];
    assign used_i     = r_used_id[r_idx];
    assign free_match = free_v && (free_i == r_frame);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_fin      <= 1'b0;
            r_hit      <= 1'b0;
            r_pos_ok   <= 1'b0;
            r_free_vld <= '1;
            r_used_vld <= '0;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_free_id[i] <= IW'(i);
            end
        end else begin
            r_fin <= 1'b0;
            if (i_cmd.start) begin
                r_run    <= 1'b1;
                r_mode   <= i_cmd.mode;
                r_frame  <= i_frame;
                r_idx    <= '0;
                r_hit    <= 1'b0;
                r_pos_ok <= 1'b0;
            end else if (r_run) begin
                unique case (r_mode)
                    SCAN_GRAB: begin
                        // take the first occupied free slot, note the first empty used slot
                        if (!r_hit && free_v) begin
                            r_hit             <= 1'b1;
                            r_take            <= free_i;
                            r_free_vld[r_idx] <= 1'b0;
                        end
                        if (!r_pos_ok && !used_v) begin
                            r_pos_ok <= 1'b1;
                            r_pos    <= r_idx;
                        end
                    end
                    default: begin
                        // purge the frame from both lists and park it in the first hole
                        if (used_v && used_i == r_frame) begin
                            r_used_vld[r_idx] <= 1'b0;
                        end
                        if (!r_hit && (!free_v || free_match)) begin
                            r_hit             <= 1'b1;
                            r_free_vld[r_idx] <= 1'b1;
                            r_free_id[r_idx]  <= r_frame;
                        end else if (free_match) begin
                            r_free_vld[r_idx] <= 1'b0;
                        end
                    end
                endcase
                if (r_idx == LAST) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (r_fin && r_mode == SCAN_GRAB && r_hit && r_pos_ok) begin
                r_used_vld[r_pos] <= 1'b1;
                r_used_id[r_pos]  <= r_take;
            end
        end
    end

    assign o_sts.done  = r_fin;
    assign o_sts.found = r_hit;
    assign o_frame     = r_take;

    `ASSERT_NEVER(a_start_while_busy, i_cmd.start && (r_run || r_fin), "scan restarted while busy")
    `ASSERT_CLK(a_idx_range, r_run |-> r_idx <= LAST, "scan index beyond last slot")
    `ASSERT_CLK(a_fin_follows_last, r_fin |-> $past(r_run) && $past(r_idx) == LAST,
        "scan finished without reaching last slot")

endmodule

// File: src/frame_buffer_pool_manager.sv
// Top level of the reference-counted frame buffer pool manager.
// Pulse start with an item while busy is low; the item is taken on that edge and busy
// stays high until the result is produced. Each item gives exactly one result, shown on
// o_result for a single cycle with o_strobe high; it cannot be held off, so capture it
// then. The slot scanner walks one slot of the free and used lists per cycle, and a
// request may need two passes (one to drop the old reference, one to take a frame).
// Errors seen from the item alone go straight to the finish state; a release of an idle
// frame goes through the release check first. A new item may be started in the strobe
// cycle.
`include "assert_macros.svh"

module frame_buffer_pool_manager #(
    parameter int FRAME_COUNT = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  fbpm_pkg::t_fbpm_in  i_item,
    output logic                o_strobe,
    output fbpm_pkg::t_fbpm_out o_result
);
    import fbpm_pkg::*;

    localparam int IW = $clog2(FRAME_COUNT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_REL_CHK,
        S_DROP,
        S_DROP_WAIT,
        S_DROP_END,
        S_GRAB,
        S_GRAB_WAIT,
        S_GRAB_SET,
        S_FIN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt [FRAME_COUNT];
    logic             r_ref_vld;
    logic [IW-1:0]    r_ref_id;
    logic             r_act;
    logic [1:0]       r_kind;
    logic [IW-1:0]    r_tgt;
    logic [2:0]       r_status;
    logic [IW-1:0]    r_granted;
    logic             r_freed;
    logic             r_strobe;
    t_fbpm_out        r_out;

    logic [CNT_W-1:0] cnt_rd;
    logic             accept;
    t_scan_cmd        scan_cmd;
    t_scan_sts        scan_sts;
    logic [IW-1:0]    scan_frame;

    assign cnt_rd = r_cnt[r_tgt];
    assign accept = start && (r_state == S_IDLE);

    assign scan_cmd.start = (r_state == S_GRAB) ||
                            (r_state == S_DROP && cnt_rd == CNT_W'(1));
    assign scan_cmd.mode  = (r_state == S_GRAB) ? SCAN_GRAB : SCAN_DROP;

    fbpm_slot_scan #(
        .FRAME_COUNT(FRAME_COUNT)
    ) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (scan_cmd),
        .i_frame(r_tgt),
        .o_sts  (scan_sts),
        .o_frame(scan_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ref_vld <= 1'b0;
            r_strobe  <= 1'b0;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act     <= i_item.action;
                        r_kind    <= i_item.frame_kind;
                        r_granted <= '0;
                        r_freed   <= 1'b0;
                        if (i_item.action == ACT_RELEASE) begin
                            if (int'(i_item.release_id) < FRAME_COUNT) begin
                                r_tgt   <= IW'(i_item.release_id);
                                r_state <= S_REL_CHK;
                            end else begin
                                r_status <= ST_REL_ERROR;
                                r_state  <= S_FIN;
                            end
                        end else if (i_item.frame_kind == KIND_KEY) begin
                            // key frame drops the old reference before taking a frame
                            if (r_ref_vld) begin
                                r_tgt     <= r_ref_id;
                                r_ref_vld <= 1'b0;
                                r_state   <= S_DROP;
                            end else begin
                                r_state <= S_GRAB;
                            end
                        end else if (!r_ref_vld) begin
                            r_status <= ST_NO_REF;
                            r_state  <= S_FIN;
                        end else if (i_item.frame_kind == KIND_UNKNOWN) begin
                            r_status <= ST_UNKNOWN;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_GRAB;
                        end
                    end
                end
                S_REL_CHK: begin
                    if (cnt_rd == '0) begin
                        r_status <= ST_REL_ERROR;
                        r_state  <= S_FIN;
                    end else begin
                        r_status <= ST_RELEASED;
                        r_state  <= S_DROP;
                    end
                end
                S_DROP: begin
                    // a stale reference with count zero changes nothing
                    if (cnt_rd != '0) begin
                        r_cnt[r_tgt] <= cnt_rd - 1'b1;
                    end
                    if (cnt_rd == CNT_W'(1)) begin
                        r_freed <= 1'b1;
                        r_state <= S_DROP_WAIT;
                    end else begin
                        r_state <= S_DROP_END;
                    end
                end
                S_DROP_WAIT: begin
                    if (scan_sts.done) begin
                        r_state <= S_DROP_END;
                    end
                end
                S_DROP_END: begin
                    if (r_act == ACT_RELEASE) begin
                        r_state <= S_FIN;
                    end else if (r_kind == KIND_KEY) begin
                        r_state <= S_GRAB;
                    end else begin
                        // motion frame: the new frame replaces the reference
                        r_ref_id <= r_granted;
                        r_state  <= S_FIN;
                    end
                end
                S_GRAB: begin
                    r_state <= S_GRAB_WAIT;
                end
                S_GRAB_WAIT: begin
                    if (scan_sts.done) begin
                        if (scan_sts.found) begin
                            r_tgt     <= scan_frame;
                            r_granted <= scan_frame;
                            r_state   <= S_GRAB_SET;
                        end else begin
                            r_status <= ST_NO_FREE;
                            r_state  <= S_FIN;
                        end
                    end
                end
                S_GRAB_SET: begin
                    r_cnt[r_tgt] <= (r_kind == KIND_EXTRA) ? CNT_SINGLE : CNT_PAIR;
                    r_status     <= ST_GRANTED;
                    if (r_kind == KIND_KEY) begin
                        r_ref_vld <= 1'b1;
                        r_ref_id  <= r_tgt;
                        r_state   <= S_FIN;
                    end else if (r_kind == KIND_MOTION) begin
                        r_tgt   <= r_ref_id;
                        r_state <= S_DROP;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_strobe           <= 1'b1;
                    r_out.status       <= r_status;
                    r_out.granted_id   <= 3'(r_granted);
                    r_out.freed        <= r_freed;
                    r_out.reference_id <= r_ref_vld ? 3'(r_ref_id) : REF_NONE;
                    r_state            <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    `ASSERT_CLK(a_strobe_single, o_strobe |=> !o_strobe, "result strobe longer than one cycle")
    `ASSERT_CLK(a_accept_busy, start && !busy |=> busy, "accepted beat did not raise busy")
    `ASSERT_CLK(a_scan_done_waited,
        scan_sts.done |-> (r_state == S_GRAB_WAIT || r_state == S_DROP_WAIT),
        "scan finished while nobody waited")
    `ASSERT_CLK(a_grant_sets_ref,
        o_strobe && o_result.status == ST_GRANTED && r_kind != KIND_EXTRA
            |-> o_result.reference_id == o_result.granted_id,
        "granted reference frame did not become the reference")

endmodule
